// File: hw/rtl/table_driven_melody_player_defines.svh
// Assertion macros for the melody player RTL.
`ifndef TABLE_DRIVEN_MELODY_PLAYER_DEFINES_SVH
`define TABLE_DRIVEN_MELODY_PLAYER_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define TDMP_ASSERT_SAME(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("tdmp same-cycle check failed");

// Check that a condition holds in the cycle after its trigger.
`define TDMP_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("tdmp next-cycle check failed");

`endif

// File: hw/rtl/tdmp_pkg.sv
// Shared types and constants of the melody player.
`timescale 1ns / 1ps

package tdmp_pkg;

   // Table geometry and entry codes
   localparam int TDMP_TABLE_DEPTH = 256;
   localparam logic [7:0] TDMP_CODE_END  = 8'h00;
   localparam logic [7:0] TDMP_CODE_REST = 8'hFF;

   // Transaction kinds on the request side
   localparam logic TDMP_KIND_TICK  = 1'b0;
   localparam logic TDMP_KIND_WRITE = 1'b1;

   // Control register indexes
   localparam logic [2:0] TDMP_CSR_PLAY_ENABLE = 3'd0;
   localparam logic [2:0] TDMP_CSR_HALF_SCALE  = 3'd1;
   localparam logic [2:0] TDMP_CSR_BEAT_LEN    = 3'd2;
   localparam logic [2:0] TDMP_CSR_REST_PAUSE  = 3'd3;
   localparam logic [2:0] TDMP_CSR_END_PAUSE   = 3'd4;

   // Control register reset values
   localparam logic [3:0]  TDMP_RST_HALF_SCALE = 4'd3;
   localparam logic [15:0] TDMP_RST_BEAT_LEN   = 16'd10000;
   localparam logic [15:0] TDMP_RST_REST_PAUSE = 16'd100;
   localparam logic [15:0] TDMP_RST_END_PAUSE  = 16'd1000;

   // Player phases
   typedef enum logic [1:0] {
      PH_FETCH = 2'd0,
      PH_NOTE  = 2'd1,
      PH_REST  = 2'd2,
      PH_END   = 2'd3
   } phase_type;

endpackage

// File: hw/rtl/table_driven_melody_player.sv
// Top level of the table-driven melody player: table, sequencer and stream ports.
`timescale 1ns / 1ps
`include "table_driven_melody_player_defines.svh"

// The player accepts one request transaction per clock cycle and returns one
// response per request from a result register in the cycle after acceptance;
// the request side stalls only while that register is full and not taken. Each
// request is either a time tick or a table write. The melody table is a memory
// with one write port and two registered read ports that always hold the entry
// at the play position and the one after it, so a fetch of a (tone, beats) pair
// completes in the tick that reaches it. The table has no reset: entries must be
// written before the player reaches them. The user must write control registers
// through the csr port while no request is outstanding; the block does not check.
module table_driven_melody_player
   import tdmp_pkg::*;
#(
   parameter int TABLE_DEPTH = TDMP_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] table_address, [15:8] table_value
   input  logic        req_tuser,   // [0] kind
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] buzzer_level, [1] note_sounding,
                                    // [9:2] play_position, [15:10] zero
   // control registers
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int AW = (IW > 8) ? IW : 8;
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

   // control registers
   logic        play_enable_ff;
   logic [3:0]  half_scale_ff;
   logic [15:0] beat_len_ff;
   logic [15:0] rest_pause_ff;
   logic [15:0] end_pause_ff;

   // player state
   logic [IW-1:0] idx_ff, idx_in;
   phase_type     phase_ff, phase_in;
   logic [7:0]    tone_ff, tone_in;
   logic [7:0]    beats_ff, beats_in;
   logic [11:0]   hp_cnt_ff, hp_cnt_in;
   logic [15:0]   bp_cnt_ff, bp_cnt_in;
   logic [15:0]   pause_ff, pause_in;
   logic          buzz_ff, buzz_in;

   // table and prefetched entries
   logic [7:0]    table_mem [TABLE_DEPTH];
   logic [7:0]    cur_entry_ff;
   logic [7:0]    nxt_entry_ff;

   // response register
   logic          rsp_valid_ff;
   logic [15:0]   rsp_data_ff;
   logic [15:0]   rsp_data_in;

   logic          req_accept;
   logic          is_tick;
   logic          is_write;
   logic [AW:0]   wr_addr_ext;
   logic          wr_en;
   logic [IW-1:0] wr_idx;
   logic [7:0]    wr_value;

   logic [IW-1:0] idx_p1;
   logic [IW-1:0] idx_p2;
   logic [IW-1:0] rd_next_addr;

   logic [3:0]    scale_eff;
   logic [11:0]   half_raw;
   logic [11:0]   half_lim;
   logic [15:0]   blen_eff;
   logic [15:0]   bp_inc;
   logic [11:0]   hp_inc;
   logic          bp_fire;
   logic          hp_fire;
   logic [7:0]    beats_dec;
   logic [15:0]   pause_dec;
   logic [AW-1:0] idx_ext;
   logic [AW-1:0] idx_ff_ext;

   // Accept a request whenever the result register is free or being drained
   assign req_accept = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign is_tick    = req_accept && (req_tuser == TDMP_KIND_TICK);
   assign is_write   = req_accept && (req_tuser == TDMP_KIND_WRITE);

   // Drop table writes beyond the table end
   assign wr_addr_ext = (AW + 1)'(req_tdata[7:0]);
   assign wr_en       = is_write && (wr_addr_ext < (AW + 1)'(TABLE_DEPTH));
   assign wr_idx      = wr_addr_ext[IW-1:0];
   assign wr_value    = req_tdata[15:8];

   // Wrap index increments at the table end
   assign idx_p1       = (idx_ff == LAST_IDX) ? '0 : idx_ff + IW'(1);
   assign idx_p2       = (idx_p1 == LAST_IDX) ? '0 : idx_p1 + IW'(1);
   assign rd_next_addr = (idx_in == LAST_IDX) ? '0 : idx_in + IW'(1);

   // Note timing limits; zero settings act as one
   assign scale_eff = (half_scale_ff == 4'd0) ? 4'd1 : half_scale_ff;
   assign half_raw  = 12'(scale_eff * tone_ff);
   assign half_lim  = (half_raw == 12'd0) ? 12'd1 : half_raw;
   assign blen_eff  = (beat_len_ff == 16'd0) ? 16'd1 : beat_len_ff;
   assign bp_inc    = bp_cnt_ff + 16'd1;
   assign hp_inc    = hp_cnt_ff + 12'd1;
   assign bp_fire   = (bp_inc >= blen_eff) || (bp_inc == 16'd0);
   assign hp_fire   = (hp_inc >= half_lim) || (hp_inc == 12'd0);
   assign beats_dec = (bp_fire && beats_ff != 8'd0) ? beats_ff - 8'd1 : beats_ff;
   assign pause_dec = (pause_ff != 16'd0) ? pause_ff - 16'd1 : 16'd0;

   // Advance the player by one tick
   always_comb begin
      idx_in    = idx_ff;
      phase_in  = phase_ff;
      tone_in   = tone_ff;
      beats_in  = beats_ff;
      hp_cnt_in = hp_cnt_ff;
      bp_cnt_in = bp_cnt_ff;
      pause_in  = pause_ff;
      buzz_in   = buzz_ff;
      if (is_tick && play_enable_ff) begin
         unique case (phase_ff)
            PH_FETCH: begin
               if (cur_entry_ff == TDMP_CODE_END) begin
                  idx_in   = '0;
                  pause_in = end_pause_ff;
                  phase_in = PH_END;
               end else if (cur_entry_ff == TDMP_CODE_REST) begin
                  idx_in   = idx_p1;
                  pause_in = rest_pause_ff;
                  phase_in = PH_REST;
               end else begin
                  tone_in   = cur_entry_ff;
                  beats_in  = nxt_entry_ff;
                  idx_in    = idx_p2;
                  hp_cnt_in = 12'd0;
                  bp_cnt_in = 16'd0;
                  phase_in  = (nxt_entry_ff != 8'd0) ? PH_NOTE : PH_FETCH;
               end
            end
            PH_NOTE: begin
               bp_cnt_in = bp_fire ? 16'd0 : bp_inc;
               beats_in  = beats_dec;
               hp_cnt_in = hp_fire ? 12'd0 : hp_inc;
               if (hp_fire) begin
                  buzz_in = !buzz_ff;
                  if (beats_dec == 8'd0) begin
                     phase_in = PH_FETCH;
                  end
               end
            end
            PH_REST, PH_END: begin
               pause_in = pause_dec;
               if (pause_dec == 16'd0) begin
                  phase_in = PH_FETCH;
               end
            end
            default: phase_in = PH_FETCH;
         endcase
      end
   end

   // Pack the response from the updated state
   assign idx_ext     = AW'(idx_in);
   assign idx_ff_ext  = AW'(idx_ff);
   assign rsp_data_in = {6'd0, idx_ext[7:0], (phase_in == PH_NOTE), buzz_in};

   // Hold control and player state
   always_ff @(posedge clock) begin
      if (reset) begin
         play_enable_ff <= 1'b0;
         half_scale_ff  <= TDMP_RST_HALF_SCALE;
         beat_len_ff    <= TDMP_RST_BEAT_LEN;
         rest_pause_ff  <= TDMP_RST_REST_PAUSE;
         end_pause_ff   <= TDMP_RST_END_PAUSE;
      end else if (csr_we) begin
         unique case (csr_index)
            TDMP_CSR_PLAY_ENABLE: play_enable_ff <= csr_wdata[0];
            TDMP_CSR_HALF_SCALE:  half_scale_ff  <= csr_wdata[3:0];
            TDMP_CSR_BEAT_LEN:    beat_len_ff    <= csr_wdata;
            TDMP_CSR_REST_PAUSE:  rest_pause_ff  <= csr_wdata;
            TDMP_CSR_END_PAUSE:   end_pause_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         phase_ff  <= PH_FETCH;
         tone_ff   <= 8'd0;
         beats_ff  <= 8'd0;
         hp_cnt_ff <= 12'd0;
         bp_cnt_ff <= 16'd0;
         pause_ff  <= 16'd0;
         buzz_ff   <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         phase_ff  <= phase_in;
         tone_ff   <= tone_in;
         beats_ff  <= beats_in;
         hp_cnt_ff <= hp_cnt_in;
         bp_cnt_ff <= bp_cnt_in;
         pause_ff  <= pause_in;
         buzz_ff   <= buzz_in;
      end
   end

   // Write the table and prefetch the entries at and after the next position
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_idx] <= wr_value;
      end
      cur_entry_ff <= (wr_en && wr_idx == idx_in) ? wr_value : table_mem[idx_in];
      nxt_entry_ff <= (wr_en && wr_idx == rd_next_addr) ? wr_value
                                                         : table_mem[rd_next_addr];
   end

   // Load the result register on accept, clear it when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Response mirrors the player state it was taken from
   `TDMP_ASSERT_SAME(a_note_flag, clock, reset, rsp_valid_ff, rsp_data_ff[1] == (phase_ff == PH_NOTE))
   `TDMP_ASSERT_SAME(a_position, clock, reset, rsp_valid_ff, rsp_data_ff[9:2] == idx_ff_ext[7:0])
   // Table writes and disabled ticks never move the player
   `TDMP_ASSERT_NEXT(a_write_hold, clock, reset, is_write || (is_tick && !play_enable_ff), $stable(idx_ff) && $stable(phase_ff))

endmodule
